// ===== design/lzd_pkg.sv =====
// Shared constants and controller/datapath interface types for the LZSS decompressor.
`default_nettype none

package lzd_pkg;

    localparam int WindowSize  = 4096;
    localparam int WinAddrBits = $clog2(WindowSize);
    localparam int CountBits   = 24;
    localparam int LenBits     = 5;
    localparam int MinMatch    = 3;

    localparam logic [WinAddrBits-1:0] StartPos = WinAddrBits'(12'hFEE);
    localparam logic [3:0]             FlagIdle = 4'd8;

    // result tdata: out_byte, run_last, bytes_out, zero pad to whole bytes
    localparam int OutUsedBits = 8 + 1 + CountBits;
    localparam int OutDataBits = ((OutUsedBits + 7) / 8) * 8;
    localparam int OutPadBits  = OutDataBits - OutUsedBits;

    typedef struct packed {
        logic take_in;
        logic load_flags;
        logic flag_step;
        logic set_halt;
        logic store_low;
        logic match_start;
        logic mread;
        logic lit_emit;
        logic mout;
        logic end_word;
        logic clear;
    } lzd_cmd_t;

    typedef struct packed {
        logic halted;
        logic need_flag;
        logic flag_bit;
        logic pending;
        logic last;
        logic lim_ok;
        logic cnt_zero;
        logic cnt_one;
        logic out_free;
    } lzd_sts_t;

endpackage

`default_nettype wire

// ===== design/lzd_ctrl.sv =====
// Sequencing state machine of the LZSS decompressor.
`default_nettype none

module lzd_ctrl
    import lzd_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire lzd_sts_t sts,
    output lzd_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LIT,
        S_MREAD,
        S_MOUT,
        S_END
    } state_t;

    state_t state_reg, state_next;
    state_t fin_state;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // an input that ends the stream closes with a word of its own when nothing else is due
    assign fin_state = sts.last ? S_END : S_IDLE;

    always_comb begin
        cmd        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (sts.halted) begin
                    state_next = fin_state;
                end else if (sts.need_flag) begin
                    cmd.load_flags = 1'b1;
                    state_next     = fin_state;
                end else if (sts.flag_bit) begin
                    cmd.flag_step = 1'b1;
                    if (sts.lim_ok) begin
                        state_next = S_LIT;
                    end else begin
                        cmd.set_halt = 1'b1;
                        state_next   = fin_state;
                    end
                end else if (!sts.pending) begin
                    cmd.store_low = 1'b1;
                    state_next    = fin_state;
                end else begin
                    cmd.match_start = 1'b1;
                    state_next      = sts.cnt_zero ? fin_state : S_MREAD;
                end
            end
            S_LIT: begin
                if (sts.out_free) begin
                    cmd.lit_emit = 1'b1;
                    cmd.clear    = sts.last;
                    state_next   = S_IDLE;
                end
            end
            S_MREAD: begin
                cmd.mread  = 1'b1;
                state_next = S_MOUT;
            end
            S_MOUT: begin
                if (sts.out_free) begin
                    cmd.mout = 1'b1;
                    if (sts.cnt_one) begin
                        cmd.clear  = sts.last;
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_MREAD;
                    end
                end
            end
            S_END: begin
                if (sts.out_free) begin
                    cmd.end_word = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/lzd_datapath.sv =====
// Window memory, stream state, limit register and output register of the LZSS decompressor.
`default_nettype none

module lzd_datapath
    import lzd_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CountBits-1:0]   cfg_wr_data,
    input  wire logic [7:0]             s_tdata,
    input  wire logic                   s_tlast,
    input  wire lzd_cmd_t               cmd,
    output lzd_sts_t                    sts,
    input  wire logic                   m_tready,
    output logic                        m_tvalid,
    output logic [OutDataBits-1:0]      m_tdata,
    output logic                        m_tuser,
    output logic                        m_tlast
);

    logic [7:0]             win_mem [WindowSize];

    logic [7:0]             in_byte_reg, in_byte_next;
    logic                   in_last_reg, in_last_next;
    logic [7:0]             flags_reg, flags_next;
    logic [3:0]             flag_idx_reg, flag_idx_next;
    logic                   pending_reg, pending_next;
    logic [7:0]             match_low_reg, match_low_next;
    logic [CountBits-1:0]   emitted_reg, emitted_next;
    logic                   halted_reg, halted_next;
    logic [CountBits-1:0]   limit_reg, limit_next;
    logic [WinAddrBits-1:0] wpos_reg, wpos_next;
    logic [WinAddrBits:0]   fill_reg, fill_next;
    logic [WinAddrBits-1:0] rpos_reg, rpos_next;
    logic [LenBits-1:0]     cnt_reg, cnt_next;
    logic [7:0]             rdata_reg;
    logic                   rvalid_reg;

    logic                   m_valid_reg, m_valid_next;
    logic [7:0]             m_byte_reg, m_byte_next;
    logic                   m_has_reg, m_has_next;
    logic                   m_run_reg, m_run_next;
    logic                   m_end_reg, m_end_next;
    logic [CountBits-1:0]   m_count_reg, m_count_next;

    logic                   emit_en;
    logic [7:0]             emit_byte;
    logic                   emit_run;
    logic [CountBits-1:0]   emitted_inc;
    logic                   lim_ok;
    logic [CountBits-1:0]   remain;
    logic [LenBits-1:0]     match_len;
    logic                   len_over;
    logic [LenBits-1:0]     start_cnt;
    logic                   start_halt;
    logic [WinAddrBits-1:0] rd_offset;
    logic                   rd_hit;
    logic                   out_free;

    // window: entries written since the stream began form a run upward from StartPos,
    // so the fill count tells whether an entry still holds its cleared value
    always_ff @(posedge aclk) begin
        if (emit_en) begin
            win_mem[wpos_reg] <= emit_byte;
        end
        if (cmd.mread) begin
            rdata_reg <= win_mem[rpos_reg];
        end
    end

    assign rd_offset = rpos_reg - StartPos;
    assign rd_hit    = {1'b0, rd_offset} < fill_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mread) begin
            rvalid_reg <= rd_hit;
        end
    end

    assign lim_ok      = emitted_reg < limit_reg;
    assign remain      = limit_reg - emitted_reg;
    assign match_len   = LenBits'(in_byte_reg[3:0]) + LenBits'(MinMatch);
    assign len_over    = CountBits'(match_len) > remain;
    assign start_cnt   = !lim_ok ? '0 : (len_over ? remain[LenBits-1:0] : match_len);
    assign start_halt  = !lim_ok || len_over;

    assign out_free    = !m_valid_reg || m_tready;
    assign emit_en     = cmd.lit_emit || cmd.mout;
    assign emit_byte   = cmd.lit_emit ? in_byte_reg : (rvalid_reg ? rdata_reg : 8'd0);
    assign emit_run    = cmd.lit_emit || (cnt_reg == LenBits'(1));
    assign emitted_inc = emitted_reg + CountBits'(1);

    always_comb begin
        in_byte_next   = in_byte_reg;
        in_last_next   = in_last_reg;
        flags_next     = flags_reg;
        flag_idx_next  = flag_idx_reg;
        pending_next   = pending_reg;
        match_low_next = match_low_reg;
        emitted_next   = emitted_reg;
        halted_next    = halted_reg;
        limit_next     = limit_reg;
        wpos_next      = wpos_reg;
        fill_next      = fill_reg;
        rpos_next      = rpos_reg;
        cnt_next       = cnt_reg;

        if (cfg_wr_en) begin
            limit_next = cfg_wr_data;
        end
        if (cmd.take_in) begin
            in_byte_next = s_tdata;
            in_last_next = s_tlast;
        end
        if (cmd.load_flags) begin
            flags_next    = in_byte_reg;
            flag_idx_next = '0;
        end
        if (cmd.flag_step) begin
            flag_idx_next = flag_idx_reg + 4'd1;
        end
        if (cmd.set_halt) begin
            halted_next = 1'b1;
        end
        if (cmd.store_low) begin
            match_low_next = in_byte_reg;
            pending_next   = 1'b1;
        end
        if (cmd.match_start) begin
            pending_next  = 1'b0;
            flag_idx_next = flag_idx_reg + 4'd1;
            rpos_next     = {in_byte_reg[7:4], match_low_reg};
            cnt_next      = start_cnt;
            if (start_halt) begin
                halted_next = 1'b1;
            end
        end
        if (emit_en) begin
            emitted_next = emitted_inc;
            wpos_next    = wpos_reg + WinAddrBits'(1);
            if (!fill_reg[WinAddrBits]) begin
                fill_next = fill_reg + (WinAddrBits+1)'(1);
            end
        end
        if (cmd.mout) begin
            rpos_next = rpos_reg + WinAddrBits'(1);
            cnt_next  = cnt_reg - LenBits'(1);
        end
        if (cmd.clear) begin
            flags_next     = '0;
            flag_idx_next  = FlagIdle;
            pending_next   = 1'b0;
            match_low_next = '0;
            emitted_next   = '0;
            halted_next    = 1'b0;
            wpos_next      = StartPos;
            fill_next      = '0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        m_byte_next  = m_byte_reg;
        m_has_next   = m_has_reg;
        m_run_next   = m_run_reg;
        m_end_next   = m_end_reg;
        m_count_next = m_count_reg;
        if (emit_en) begin
            m_valid_next = 1'b1;
            m_byte_next  = emit_byte;
            m_has_next   = 1'b1;
            m_run_next   = emit_run;
            m_end_next   = emit_run && in_last_reg;
            m_count_next = emitted_inc;
        end else if (cmd.end_word) begin
            m_valid_next = 1'b1;
            m_byte_next  = 8'd0;
            m_has_next   = 1'b0;
            m_run_next   = 1'b1;
            m_end_next   = 1'b1;
            m_count_next = emitted_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg     <= '0;
            flag_idx_reg  <= FlagIdle;
            pending_reg   <= 1'b0;
            match_low_reg <= '0;
            emitted_reg   <= '0;
            halted_reg    <= 1'b0;
            limit_reg     <= '0;
            wpos_reg      <= StartPos;
            fill_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            flags_reg     <= flags_next;
            flag_idx_reg  <= flag_idx_next;
            pending_reg   <= pending_next;
            match_low_reg <= match_low_next;
            emitted_reg   <= emitted_next;
            halted_reg    <= halted_next;
            limit_reg     <= limit_next;
            wpos_reg      <= wpos_next;
            fill_reg      <= fill_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
        in_last_reg <= in_last_next;
        rpos_reg    <= rpos_next;
        cnt_reg     <= cnt_next;
        m_byte_reg  <= m_byte_next;
        m_has_reg   <= m_has_next;
        m_run_reg   <= m_run_next;
        m_end_reg   <= m_end_next;
        m_count_reg <= m_count_next;
    end

    assign sts.halted    = halted_reg;
    assign sts.need_flag = flag_idx_reg[3];
    assign sts.flag_bit  = flags_reg[flag_idx_reg[2:0]];
    assign sts.pending   = pending_reg;
    assign sts.last      = in_last_reg;
    assign sts.lim_ok    = lim_ok;
    assign sts.cnt_zero  = (start_cnt == '0);
    assign sts.cnt_one   = (cnt_reg == LenBits'(1));
    assign sts.out_free  = out_free;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{OutPadBits{1'b0}}, m_count_reg, m_run_reg, m_byte_reg};
    assign m_tuser  = m_has_reg;
    assign m_tlast  = m_end_reg;

endmodule

`default_nettype wire

// ===== design/lzss_decompressor_core.sv =====
// Top level of the LZSS decompressor with a 4096-byte window.
//
// Usage:
//   s_ channel takes one compressed byte per word (s_tdata), s_tlast marks the
//   final byte of the stream. m_ channel returns decompressed bytes, at most one per word.
//   cfg_wr_en / cfg_wr_data load output_limit, the most bytes emitted per stream;
//   write it only while the block is idle.
// Sequencing (one word in process at a time; s_tready is high only when idle):
//   flag byte, first match byte, ignored byte: accept, then decode
//   literal: accept, decode, then the byte is loaded into the output register
//   second match byte: accept, decode, then for each copied byte a window read
//   into a register and an output load
//   a stream end that emits nothing adds a closing word
// Reset: control state returns to the start of a stream and output_limit to 0.
//   The window needs no clearing pass: a fill count marks entries not yet
//   written in this stream, and those read as zero. The same holds after each
//   stream end, so a new stream may follow at once.
// Stall: the result sits in the output register until m_tready; the block
//   waits with it and accepts nothing new until its words are all loaded.
`default_nettype none

module lzss_decompressor_core
    import lzd_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // configuration: output_limit
    input  wire logic                   cfg_wr_en,
    input  wire logic [CountBits-1:0]   cfg_wr_data,
    // compressed input
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // [7:0] in_byte
    input  wire logic                   s_tlast,   // last_byte
    // decompressed output
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OutDataBits-1:0]      m_tdata,   // [7:0] out_byte, [8] run_last,
                                                   // [32:9] bytes_out, rest zero
    output logic                        m_tuser,   // has_data
    output logic                        m_tlast    // stream_end
);

    lzd_cmd_t cmd;
    lzd_sts_t sts;

    // sequencing: decode of each word, copy loop of matches, closing word
    lzd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // window, flag/match state, byte counter and limit, output register
    lzd_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .cmd         (cmd),
        .sts         (sts),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire

// ===== design/lzd_chk.sv =====
// Port-level checker for the LZSS decompressor, bound to the top level.
`default_nettype none

module lzd_chk
    import lzd_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OutDataBits-1:0] m_tdata,
    input wire logic                   m_tuser,
    input wire logic                   m_tlast
);

    // stalled output word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_rst_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // a word without data is only the closing word of a stream, with a zero byte
    a_nodata: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata[7:0] == 8'd0))
        else $error("bad empty word");

    a_end_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[8])
        else $error("stream end without run_last");

    // one input word at a time: busy right after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted back to back");

endmodule

bind lzss_decompressor_core lzd_chk u_chk (.*);

`default_nettype wire
